[design/sorted_table_interpolation_search_defines.svh]
// ----------------------------------------------------------------------------
// Sorted table interpolation search: assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_INTERPOLATION_SEARCH_DEFINES_SVH
`define SORTED_TABLE_INTERPOLATION_SEARCH_DEFINES_SVH

// same-cycle implication
`define STIS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stis check failed");

// next-cycle implication
`define STIS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stis check failed");

`endif

[design/stis_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted table interpolation search: package
// Widths, defaults and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package stis_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int LEN_W   = 11;
   localparam int INDEX_W = 10;
   localparam int VALUE_W = 32;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic [1:0] RD_LO   = 2'd0;
   localparam logic [1:0] RD_HI   = 2'd1;
   localparam logic [1:0] RD_POS  = 2'd2;
   localparam logic [1:0] RD_SCAN = 2'd3;

   typedef struct packed {
      logic       mem_wr;
      logic       capture;
      logic [1:0] rd_sel;
      logic       lat_elo;
      logic       lat_ehi;
      logic       mul;
      logic       div_step;
      logic       pos_calc;
      logic       go_upper;
      logic       go_lower;
      logic       scan_init;
      logic       scan_next;
      logic       hit_lo;
      logic       hit_pos;
      logic       hit_scan;
      logic       miss;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic load_ok;
      logic n_zero;
      logic in_range;
      logic lo_eq_hi;
      logic elo_hit;
      logic spread_zero;
      logic div_done;
      logic pr_eq;
      logic pr_lt;
      logic pos_at_lo;
      logic pos_at_hi;
      logic scan_eq;
      logic scan_end;
   } status_type;

endpackage

`default_nettype wire

[design/stis_req_if.sv]
// ----------------------------------------------------------------------------
// Sorted table interpolation search: request channel
// Valid/ready channel carrying a load or search item.
// ----------------------------------------------------------------------------
`default_nettype none

interface stis_req_if;
   logic                               valid;
   logic                               ready;
   logic                               operation;
   logic [stis_pkg::INDEX_W-1:0]       entry_index;
   logic signed [stis_pkg::VALUE_W-1:0] entry_value;
   logic signed [stis_pkg::VALUE_W-1:0] target;

   modport source (output valid, operation, entry_index, entry_value, target, input ready);
   modport sink   (input valid, operation, entry_index, entry_value, target, output ready);
endinterface

`default_nettype wire

[design/stis_rsp_if.sv]
// ----------------------------------------------------------------------------
// Sorted table interpolation search: response channel
// Valid/ready channel carrying one search result.
// ----------------------------------------------------------------------------
`default_nettype none

interface stis_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [stis_pkg::INDEX_W-1:0] position;

   modport source (output valid, found, position, input ready);
   modport sink   (input valid, found, position, output ready);
endinterface

`default_nettype wire

[design/stis_csr_if.sv]
// ----------------------------------------------------------------------------
// Sorted table interpolation search: register write channel
// Valid/ready channel carrying the table length.
// ----------------------------------------------------------------------------
`default_nettype none

interface stis_csr_if;
   logic                       valid;
   logic                       ready;
   logic [stis_pkg::LEN_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[design/stis_datapath.sv]
// ----------------------------------------------------------------------------
// Sorted table interpolation search: datapath
// Table memory, search bounds, multiplier, radix-2 divider and result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module stis_datapath #(
   parameter int TABLE_DEPTH = stis_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire stis_pkg::cmd_type                  cmd,
   output stis_pkg::status_type                    sts,
   input  wire logic                               csr_wr,
   input  wire logic [stis_pkg::LEN_W-1:0]         csr_data,
   input  wire logic                               req_operation,
   input  wire logic [stis_pkg::INDEX_W-1:0]       req_entry_index,
   input  wire logic signed [stis_pkg::VALUE_W-1:0] req_entry_value,
   input  wire logic signed [stis_pkg::VALUE_W-1:0] req_target,
   output logic                                    rsp_found,
   output logic [stis_pkg::INDEX_W-1:0]            rsp_position
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int NW = stis_pkg::VALUE_W + AW;
   localparam int CW = $clog2(AW + 1);
   localparam int VW = stis_pkg::VALUE_W;

   logic signed [VW-1:0] mem [TABLE_DEPTH];
   logic signed [VW-1:0] rdata_ff;
   logic [AW-1:0]        rd_addr;

   logic [stis_pkg::LEN_W-1:0] len_ff;
   logic signed [VW-1:0]       tgt_ff, elo_ff, ehi_ff;
   logic [AW-1:0]              lo_ff, hi_ff, pos_ff, scan_ff;
   logic [NW-1:0]              num_ff;
   logic [VW-1:0]              spread_ff, rem_ff;
   logic [AW-1:0]              nsh_ff, q_ff;
   logic [CW-1:0]              cnt_ff;
   logic                       res_found_ff;
   logic [AW-1:0]              res_pos_ff;
   logic                       rsp_found_ff;
   logic [stis_pkg::INDEX_W-1:0] rsp_position_ff;

   logic [31:0]   len_eff;
   logic [VW:0]   diff, sprd;
   logic [VW:0]   shifted;
   logic          ge;
   logic [AW:0]   sum;

   always_comb begin
      if (32'(len_ff) > 32'(TABLE_DEPTH)) begin
         len_eff = 32'(TABLE_DEPTH);
      end else begin
         len_eff = 32'(len_ff);
      end
      diff    = {tgt_ff[VW-1], tgt_ff} - {elo_ff[VW-1], elo_ff};
      sprd    = {ehi_ff[VW-1], ehi_ff} - {elo_ff[VW-1], elo_ff};
      shifted = {rem_ff, nsh_ff[AW-1]};
      ge      = shifted >= {1'b0, spread_ff};
      sum     = {1'b0, lo_ff} + {1'b0, q_ff};
      case (cmd.rd_sel)
         stis_pkg::RD_LO:   rd_addr = lo_ff;
         stis_pkg::RD_HI:   rd_addr = hi_ff;
         stis_pkg::RD_POS:  rd_addr = pos_ff;
         stis_pkg::RD_SCAN: rd_addr = scan_ff;
         default:           rd_addr = lo_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[AW'(req_entry_index)] <= req_entry_value;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (csr_wr) begin
         len_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tgt_ff <= req_target;
         lo_ff  <= '0;
         hi_ff  <= AW'(len_eff - 32'd1);
      end
      if (cmd.go_upper) begin
         lo_ff <= pos_ff + AW'(1);
      end
      if (cmd.go_lower) begin
         hi_ff <= pos_ff - AW'(1);
      end
      if (cmd.lat_elo) begin
         elo_ff <= rdata_ff;
      end
      if (cmd.lat_ehi) begin
         ehi_ff <= rdata_ff;
      end
      if (cmd.mul) begin
         num_ff    <= NW'(diff[VW-1:0]) * NW'(hi_ff - lo_ff);
         spread_ff <= sprd[VW-1:0];
         cnt_ff    <= CW'(AW + 1);
      end
      if (cmd.div_step) begin
         if (cnt_ff == CW'(AW + 1)) begin
            rem_ff <= num_ff[NW-1:AW];
            nsh_ff <= num_ff[AW-1:0];
            q_ff   <= '0;
         end else begin
            rem_ff <= ge ? VW'(shifted - {1'b0, spread_ff}) : shifted[VW-1:0];
            nsh_ff <= nsh_ff << 1;
            q_ff   <= (q_ff << 1) | AW'(ge);
         end
         cnt_ff <= cnt_ff - CW'(1);
      end
      if (cmd.pos_calc) begin
         pos_ff <= (sum > {1'b0, hi_ff}) ? hi_ff : sum[AW-1:0];
      end
      if (cmd.scan_init) begin
         scan_ff <= lo_ff;
      end
      if (cmd.scan_next) begin
         scan_ff <= scan_ff + AW'(1);
      end
      if (cmd.hit_lo) begin
         res_found_ff <= 1'b1;
         res_pos_ff   <= lo_ff;
      end
      if (cmd.hit_pos) begin
         res_found_ff <= 1'b1;
         res_pos_ff   <= pos_ff;
      end
      if (cmd.hit_scan) begin
         res_found_ff <= 1'b1;
         res_pos_ff   <= scan_ff;
      end
      if (cmd.miss) begin
         res_found_ff <= 1'b0;
         res_pos_ff   <= '0;
      end
      if (cmd.rsp_load) begin
         rsp_found_ff    <= res_found_ff;
         rsp_position_ff <= stis_pkg::INDEX_W'(res_pos_ff);
      end
   end

   always_comb begin
      sts.is_load     = req_operation == stis_pkg::OP_LOAD;
      sts.load_ok     = 32'(req_entry_index) < 32'(TABLE_DEPTH);
      sts.n_zero      = len_eff == 32'd0;
      sts.in_range    = (tgt_ff >= elo_ff) && (tgt_ff <= ehi_ff);
      sts.lo_eq_hi    = lo_ff == hi_ff;
      sts.elo_hit     = elo_ff == tgt_ff;
      sts.spread_zero = elo_ff == ehi_ff;
      sts.div_done    = cnt_ff == '0;
      sts.pr_eq       = rdata_ff == tgt_ff;
      sts.pr_lt       = rdata_ff < tgt_ff;
      sts.pos_at_lo   = pos_ff == lo_ff;
      sts.pos_at_hi   = pos_ff == hi_ff;
      sts.scan_eq     = rdata_ff == tgt_ff;
      sts.scan_end    = scan_ff == hi_ff;
   end

   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

endmodule

`default_nettype wire

[design/stis_ctrl.sv]
// ----------------------------------------------------------------------------
// Sorted table interpolation search: controller
// Sequences loads, probes, divisions, linear scans and the response handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module stis_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire stis_pkg::status_type sts,
   output stis_pkg::cmd_type         cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RLO   = 4'd1;
   localparam logic [3:0] S_RHI   = 4'd2;
   localparam logic [3:0] S_LATHI = 4'd3;
   localparam logic [3:0] S_EVAL  = 4'd4;
   localparam logic [3:0] S_MUL   = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_POS   = 4'd7;
   localparam logic [3:0] S_PRD   = 4'd8;
   localparam logic [3:0] S_PCMP  = 4'd9;
   localparam logic [3:0] S_LRD   = 4'd10;
   localparam logic [3:0] S_LCMP  = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = state_ff == S_IDLE;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = stis_pkg::RD_LO;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (sts.is_load) begin
                  cmd.mem_wr = sts.load_ok;
               end else begin
                  cmd.capture = 1'b1;
                  if (sts.n_zero) begin
                     cmd.miss = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_RLO;
                  end
               end
            end
         end
         S_RLO: begin
            cmd.rd_sel = stis_pkg::RD_LO;
            state_in   = S_RHI;
         end
         S_RHI: begin
            cmd.lat_elo = 1'b1;
            cmd.rd_sel  = stis_pkg::RD_HI;
            state_in    = S_LATHI;
         end
         S_LATHI: begin
            cmd.lat_ehi = 1'b1;
            state_in    = S_EVAL;
         end
         S_EVAL: begin
            if (!sts.in_range) begin
               cmd.miss = 1'b1;
               state_in = S_DONE;
            end else if (sts.lo_eq_hi) begin
               cmd.hit_lo = sts.elo_hit;
               cmd.miss   = !sts.elo_hit;
               state_in   = S_DONE;
            end else if (sts.spread_zero) begin
               cmd.scan_init = 1'b1;
               state_in      = S_LRD;
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.div_step = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.pos_calc = 1'b1;
               state_in     = S_POS;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_POS: begin
            cmd.rd_sel = stis_pkg::RD_POS;
            state_in   = S_PRD;
         end
         S_PRD: begin
            cmd.rd_sel = stis_pkg::RD_POS;
            state_in   = S_PCMP;
         end
         S_PCMP: begin
            if (sts.pr_eq) begin
               cmd.hit_pos = 1'b1;
               state_in    = S_DONE;
            end else if (sts.pr_lt) begin
               if (sts.pos_at_hi) begin
                  cmd.miss = 1'b1;
                  state_in = S_DONE;
               end else begin
                  cmd.go_upper = 1'b1;
                  state_in     = S_RLO;
               end
            end else begin
               if (sts.pos_at_lo) begin
                  cmd.miss = 1'b1;
                  state_in = S_DONE;
               end else begin
                  cmd.go_lower = 1'b1;
                  state_in     = S_RLO;
               end
            end
         end
         S_LRD: begin
            cmd.rd_sel = stis_pkg::RD_SCAN;
            state_in   = S_LCMP;
         end
         S_LCMP: begin
            if (sts.scan_eq) begin
               cmd.hit_scan = 1'b1;
               state_in     = S_DONE;
            end else if (sts.scan_end) begin
               cmd.miss = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_LRD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[design/sorted_table_interpolation_search.sv]
// ----------------------------------------------------------------------------
// Sorted table interpolation search: top level
// Loads a sorted table and interpolation-searches it for a target.
//
//   channel   dir  payload
//   req_if    in   operation, entry_index, entry_value, target
//   rsp_if    out  found, position
//   csr_if    in   data (table_length)
//
// A load writes the table when accepted. A search reads both bounds, then,
// per probe, multiplies and runs the one-bit-per-cycle divider before
// reading the probe entry; a zero spread scans the range entry by entry.
// The table memory has no reset; the length register resets to zero.
// A finished result waits in the response register while the next item enters.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_interpolation_search #(
   parameter int TABLE_DEPTH = stis_pkg::TABLE_DEPTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   stis_req_if.sink   req_if,
   stis_rsp_if.source rsp_if,
   stis_csr_if.sink   csr_if
);

   stis_pkg::cmd_type    cmd;
   stis_pkg::status_type sts;

   assign csr_if.ready = 1'b1;

   stis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stis_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_wr          (csr_if.valid),
      .csr_data        (csr_if.data),
      .req_operation   (req_if.operation),
      .req_entry_index (req_if.entry_index),
      .req_entry_value (req_if.entry_value),
      .req_target      (req_if.target),
      .rsp_found       (rsp_if.found),
      .rsp_position    (rsp_if.position)
   );

endmodule

`default_nettype wire

[design/stis_checker.sv]
// ----------------------------------------------------------------------------
// Sorted table interpolation search: port checker
// Observes the top-level channels and flags response-side slips.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_table_interpolation_search_defines.svh"

module stis_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         req_operation,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic                         rsp_found,
   input wire logic [stis_pkg::INDEX_W-1:0] rsp_position
);

   `STIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `STIS_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_valid && !rsp_found, rsp_position == '0)
   `STIS_ASSERT_NEXT(a_load_silent, clock, reset, req_valid && req_ready && (req_operation == stis_pkg::OP_LOAD), !$rose(rsp_valid))

endmodule

bind sorted_table_interpolation_search stis_checker u_stis_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .req_operation (req_if.operation),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_found     (rsp_if.found),
   .rsp_position  (rsp_if.position)
);

`default_nettype wire
